// ===== rtl/core/asmix_pkg.sv =====
// Shared types, codes and constant tables for the audio source mixer and sampler.
package asmix_pkg;

  // Default number of fractional bits in the voltage arithmetic.
  localparam int unsigned FRAC_BITS_DEF = 12;

  // Configuration port geometry and register indexes.
  localparam int unsigned CFG_IW = 2;
  localparam int unsigned CFG_DW = 16;
  localparam logic [CFG_IW-1:0] CFG_VOLUME = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_FORMAT = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_PERIOD = 2'd2;

  // Register reset values.
  localparam int unsigned VOLUME_RESET = 100;
  localparam logic [15:0] PERIOD_RESET = 16'd325;

  // Sample format codes; with the top bit set, ticks emit nothing and updates repeat the held sample.
  localparam logic [2:0] FMT_U8       = 3'd0;
  localparam logic [2:0] FMT_S8       = 3'd1;
  localparam logic [2:0] FMT_S16      = 3'd2;
  localparam logic [2:0] FMT_S16_SWAP = 3'd3;

  // Input opcodes and output kinds.
  localparam logic OP_TICK     = 1'b0;
  localparam logic OP_UPDATE   = 1'b1;
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Source rows of the gain/offset table; the last row is the muted mux.
  localparam int unsigned NUM_SRC_ROWS  = 5;
  localparam int unsigned NUM_LINE_ROWS = 3;
  localparam logic [2:0] SRC_DAC   = 3'd0;
  localparam logic [2:0] SRC_TAPE  = 3'd1;
  localparam logic [2:0] SRC_MUTED = 3'd4;

  // Single-bit line rows: driven differently, both low, both high.
  localparam logic [1:0] LINE_SPLIT = 2'd0;
  localparam logic [1:0] LINE_LOW   = 2'd1;
  localparam logic [1:0] LINE_HIGH  = 2'd2;

  // Gains and offsets in millivolts, by source row and line row.
  localparam int unsigned GAIN_MV [0:NUM_SRC_ROWS-1][0:NUM_LINE_ROWS-1] = '{
    '{4500, 2840, 3400},
    '{500, 400, 500},
    '{0, 0, 0},
    '{0, 0, 0},
    '{0, 0, 0}
  };
  localparam int unsigned OFFSET_MV [0:NUM_SRC_ROWS-1][0:NUM_LINE_ROWS-1] = '{
    '{200, 180, 1300},
    '{2050, 1600, 2350},
    '{0, 0, 3900},
    '{0, 0, 10},
    '{0, 0, 3900}
  };

  // Comparator threshold in millivolts.
  localparam int unsigned SENSE_MV = 1414;

  // Volume scale width; full volume gives 6971.
  localparam int unsigned SCALE_W = 13;

  // Millivolts to rounded fixed point volts (used at elaboration only).
  function automatic longint unsigned mv_fx(int unsigned mv, int unsigned frac);
    return ((longint'(mv) << frac) + 64'd500) / 64'd1000;
  endfunction

  // Volume percent to output scale, saturating at full volume.
  function automatic int unsigned scale_of(int unsigned vol);
    int unsigned v;
    v = (vol > 100) ? 100 : vol;
    return (32767 * v) / 470;
  endfunction

  // Fields of an update beat.
  typedef struct packed {
    logic [7:0] tape_level;
    logic [5:0] dac_value;
    logic       bit_sink;
    logic       bit_source;
    logic [1:0] source_select;
    logic       mux_enable;
  } asmix_update_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic tick;
    logic divide;
    logic scale;
    logic finish;
  } asmix_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } asmix_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCALE,
    ST_PACK
  } asmix_state_t;

endpackage

// ===== rtl/core/asmix_datapath.sv =====
// Datapath: configuration registers, tick divider, voltage arithmetic and output register.
module asmix_datapath
  import asmix_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  input  asmix_update_t     upd,
  input  asmix_cmd_t        cmd,
  output asmix_status_t     status,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              out_kind,
  output logic [15:0]       out_sample,
  output logic              out_sense
);

  // Volts carry three integer bits; products grow by the code width.
  localparam int unsigned VW  = FRAC_BITS + 3;
  localparam int unsigned XW  = VW + 8;
  localparam int unsigned KSH = XW + 8;
  localparam int unsigned MW  = KSH - 5;
  localparam int unsigned PW  = VW + SCALE_W;
  localparam longint unsigned RECIP_DAC_L  = ((64'd1 << KSH) + 64'd62) / 64'd63;
  localparam longint unsigned RECIP_TAPE_L = ((64'd1 << KSH) + 64'd254) / 64'd255;
  localparam logic [MW-1:0] RECIP_DAC  = MW'(RECIP_DAC_L);
  localparam logic [MW-1:0] RECIP_TAPE = MW'(RECIP_TAPE_L);
  localparam logic [VW-1:0] SENSE_TH   = VW'(mv_fx(SENSE_MV, FRAC_BITS));

  // Constant tables built at elaboration.
  logic [VW-1:0]      gain_tab [0:NUM_SRC_ROWS-1][0:NUM_LINE_ROWS-1];
  logic [VW-1:0]      offset_tab [0:NUM_SRC_ROWS-1][0:NUM_LINE_ROWS-1];
  logic [SCALE_W-1:0] scale_tab [0:127];

  for (genvar gs = 0; gs < NUM_SRC_ROWS; gs++) begin : g_src
    for (genvar gr = 0; gr < NUM_LINE_ROWS; gr++) begin : g_row
      assign gain_tab[gs][gr]   = VW'(mv_fx(GAIN_MV[gs][gr], FRAC_BITS));
      assign offset_tab[gs][gr] = VW'(mv_fx(OFFSET_MV[gs][gr], FRAC_BITS));
    end
  end

  for (genvar gv = 0; gv < 128; gv++) begin : g_scale
    assign scale_tab[gv] = SCALE_W'(scale_of(gv));
  end

  // Configuration and sequence state.
  logic [SCALE_W-1:0] scale;
  logic [2:0]         fmt;
  logic [15:0]        period;
  logic [15:0]        held;
  logic [15:0]        tick_count;

  // Pipeline payload registers.
  logic [XW-1:0] x_reg;
  logic [VW-1:0] off_reg;
  logic          is_tape;
  logic          line_split;
  logic [VW-1:0] q_reg;
  logic [PW-1:0] prod_reg;
  logic          sense_reg;

  // Table lookup and level code for an incoming update.
  logic [2:0]    src_idx;
  logic [1:0]    line_row;
  logic [7:0]    code;
  logic [VW-1:0] gain_sel;

  always_comb begin
    src_idx  = upd.mux_enable ? {1'b0, upd.source_select} : SRC_MUTED;
    line_row = (upd.bit_source != upd.bit_sink) ? LINE_SPLIT :
               (upd.bit_source ? LINE_HIGH : LINE_LOW);
    gain_sel = gain_tab[src_idx][line_row];
    if (src_idx == SRC_DAC) begin
      code = {2'b00, upd.dac_value};
    end else if (src_idx == SRC_TAPE) begin
      code = upd.tape_level;
    end else begin
      code = 8'd0;
    end
  end

  // Exact divide by 63 or 255 through a reciprocal multiply.
  logic [MW-1:0]    recip;
  logic [XW+MW-1:0] div_prod;

  assign recip    = is_tape ? RECIP_TAPE : RECIP_DAC;
  assign div_prod = (XW + MW)'(x_reg) * (XW + MW)'(recip);

  // Output voltage and comparator.
  logic [VW-1:0] v_sum;

  assign v_sum = VW'({1'b0, off_reg} + {1'b0, q_reg});

  // Scaled sample and format packing.
  logic [15:0] o_val;
  logic [15:0] held_new;

  assign o_val = prod_reg[FRAC_BITS +: 16];

  always_comb begin
    unique case (fmt)
      FMT_U8:       held_new = {8'h00, o_val[15:8] + 8'h80};
      FMT_S8:       held_new = {8'h00, o_val[15:8]};
      FMT_S16:      held_new = o_val;
      FMT_S16_SWAP: held_new = {o_val[7:0], o_val[15:8]};
      default:      held_new = held;
    endcase
  end

  // Tick divider; a zero period acts as one.
  logic [15:0] period_eff;
  logic [16:0] tick_next;
  logic        tick_hit;
  logic        tick_emit;

  assign period_eff = (period == 16'd0) ? 16'd1 : period;
  assign tick_next  = {1'b0, tick_count} + 17'd1;
  assign tick_hit   = tick_next >= {1'b0, period_eff};
  assign tick_emit  = cmd.tick && tick_hit && !fmt[2];

  assign status.out_free = !out_valid || out_ready;

  // Configuration, divider count, held sample and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale      <= scale_tab[7'(VOLUME_RESET)];
      fmt        <= FMT_S16;
      period     <= PERIOD_RESET;
      held       <= 16'h0000;
      tick_count <= 16'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_VOLUME: scale <= scale_tab[cfg_data[6:0]];
          CFG_FORMAT: begin
            fmt  <= cfg_data[2:0];
            held <= (cfg_data[2:0] == FMT_U8) ? 16'h0080 : 16'h0000;
          end
          CFG_PERIOD: period <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.tick) begin
        tick_count <= tick_hit ? 16'd0 : tick_next[15:0];
      end
      if (cmd.finish) begin
        held <= held_new;
      end
      if (tick_emit || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Update pipeline stages and output payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg      <= XW'(code) * XW'(gain_sel);
      off_reg    <= offset_tab[src_idx][line_row];
      is_tape    <= (src_idx == SRC_TAPE);
      line_split <= (line_row == LINE_SPLIT);
    end
    if (cmd.divide) begin
      q_reg <= div_prod[KSH +: VW];
    end
    if (cmd.scale) begin
      prod_reg  <= PW'(v_sum) * PW'(scale);
      sense_reg <= !(line_split && (v_sum < SENSE_TH));
    end
    if (tick_emit) begin
      out_kind   <= KIND_SAMPLE;
      out_sample <= held;
      out_sense  <= 1'b0;
    end else if (cmd.finish) begin
      out_kind   <= KIND_UPDATE;
      out_sample <= held_new;
      out_sense  <= sense_reg;
    end
  end

endmodule

// ===== rtl/core/asmix_ctrl.sv =====
// Controller: accepts beats and sequences the update arithmetic.
module asmix_ctrl
  import asmix_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_opcode,
  output logic          in_ready,
  input  asmix_status_t status,
  output asmix_cmd_t    cmd
);

  asmix_state_t state;
  asmix_state_t state_next;

  logic accept;

  // Ticks need the output slot at once; updates find it free later.
  assign in_ready = (state == ST_IDLE) && (status.out_free || (in_opcode == OP_UPDATE));
  assign accept   = in_valid && in_ready;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (in_opcode == OP_UPDATE)) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: state_next = ST_SCALE;
      ST_SCALE:  state_next = ST_PACK;
      ST_PACK: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.load = accept && (in_opcode == OP_UPDATE);
        cmd.tick = accept && (in_opcode == OP_TICK);
      end
      ST_DIVIDE: cmd.divide = 1'b1;
      ST_SCALE:  cmd.scale  = 1'b1;
      ST_PACK:   cmd.finish = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef ASSERT_OFF
  // No beat is taken while an update is in flight.
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("beat accepted while busy");

  // An accepted update steps through the DIVIDE and SCALE states in turn, running divide and then scale.
  a_load_then_divide: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.divide)
    else $error("divide did not follow load");

  a_divide_then_scale: assert property (@(posedge clk) disable iff (rst)
    cmd.divide |=> cmd.scale)
    else $error("scale did not follow divide");

  // The result is written only into a free output slot.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("finish into a full output slot");

  // At most one command at a time.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.tick, cmd.divide, cmd.scale, cmd.finish}))
    else $error("overlapping commands");
`endif

endmodule

// ===== rtl/core/audio_source_mixer_sampler_core.sv =====
// Tick beats: one per cycle while idle and the output drains; a tick that ends the period in an
// emitting format puts the held sample in the output register next cycle. Update beats: level
// multiply at acceptance, then divide, volume multiply and pack; the three registered multiplies
// are run in turn by the controller, pack waits for a free output slot, no beat is taken meanwhile.
// Reset (rst, synchronous): volume 100, format s16, period 325, held sample and tick count
// cleared, no beat pending at the output.
module audio_source_mixer_sampler_core
  import asmix_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration write port.
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  // Input stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [0] mux_enable, [2:1] source_select, [3] bit_source, [4] bit_sink,
  // [10:5] dac_value, [18:11] tape_level, [23:19] zero
  input  logic [23:0]       s_axis_tdata,
  // [0] opcode
  input  logic              s_axis_tuser,
  // Output stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] sample, [16] sense_bit, [23:17] zero
  output logic [23:0]       m_axis_tdata,
  // [0] kind
  output logic              m_axis_tuser
);

  asmix_update_t upd;
  asmix_cmd_t    cmd;
  asmix_status_t status;
  logic [15:0]   out_sample;
  logic          out_sense;

  assign upd = s_axis_tdata[18:0];

  asmix_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_opcode (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  asmix_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .upd        (upd),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_kind   (m_axis_tuser),
    .out_sample (out_sample),
    .out_sense  (out_sense)
  );

  assign m_axis_tdata = {7'd0, out_sense, out_sample};

endmodule

// ===== test/audio_source_mixer_sampler_core_test.sv =====
// Self-checking testbench for the audio source mixer and sampler core.
module audio_source_mixer_sampler_core_test;
  import asmix_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_BEATS = 93;
  localparam int unsigned SENSE_THRESH_MV = 1414;
  localparam logic [CFG_IW-1:0] CFG_SPARE = 2'd3;
  localparam logic [2:0] FMT_NONE_LO = 3'd4;
  localparam logic [2:0] FMT_NONE_HI = 3'd7;
  localparam logic [7:0] U8_BIAS = 8'h80;

  // Gain and offset per source row (DAC, tape, cartridge, none, muted) and line row.
  localparam int unsigned SRC_GAIN_MV [5][3] = '{
    '{4500, 2840, 3400}, '{500, 400, 500}, '{0, 0, 0}, '{0, 0, 0}, '{0, 0, 0}
  };
  localparam int unsigned SRC_OFFSET_MV [5][3] = '{
    '{200, 180, 1300}, '{2050, 1600, 2350}, '{0, 0, 3900}, '{0, 0, 10}, '{0, 0, 3900}
  };

  typedef struct packed {
    logic        kind;
    logic [15:0] sample;
    logic        sense;
  } mix_out_t;

  // One row of the directed script: a register write or a beat.
  typedef struct {
    bit                is_reg;
    logic [CFG_IW-1:0] reg_idx;
    logic [CFG_DW-1:0] reg_val;
    logic              op;
    asmix_update_t     f;
    bit                typed;
    mix_out_t          want;
  } dir_row_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKED,
    RX_PERIODIC
  } rx_style_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // [0] mux_enable, [2:1] source_select, [3] bit_source, [4] bit_sink,
  // [10:5] dac_value, [18:11] tape_level, [23:19] zero
  logic [23:0] s_axis_tdata;
  // [0] opcode
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // [15:0] sample, [16] sense_bit, [23:17] zero
  logic [23:0] m_axis_tdata;
  // [0] kind
  logic m_axis_tuser;

  // Mirror of the block's registers and state.
  logic [6:0]  vol_pct;
  logic [2:0]  fmt_code;
  logic [15:0] period_word;
  logic [15:0] held_word;
  logic [15:0] tick_cnt;

  mix_out_t due_beats[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 0;
  bit bursty = 1'b1;
  bit hold_req = 1'b0;

  audio_source_mixer_sampler_core DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Millivolts to rounded fixed-point volts.
  function automatic longint unsigned mv_volts(input int unsigned mv);
    return ((longint'(mv) << FRAC) + 64'd500) / 64'd1000;
  endfunction

  function automatic logic [15:0] silence_of(input logic [2:0] fmt);
    return (fmt == FMT_U8) ? {8'h00, U8_BIAS} : 16'h0000;
  endfunction

  // Register write as the block sees it.
  function automatic void apply_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    case (idx)
      CFG_VOLUME: vol_pct = val[6:0];
      CFG_FORMAT: begin
        fmt_code = val[2:0];
        held_word = silence_of(fmt_code);
      end
      CFG_PERIOD: period_word = val;
      default: ;
    endcase
  endfunction

  // Advances the mirror by one beat; returns 1 when the beat produces an output beat.
  function automatic bit mixer_step(input logic op, input asmix_update_t f, output mix_out_t r);
    logic [15:0] per;
    logic [16:0] nxt;
    logic [2:0] src;
    logic [1:0] row;
    bit split;
    longint unsigned gain;
    longint unsigned volts;
    longint unsigned scale;
    logic [15:0] o;
    r = '0;
    if (op == OP_TICK) begin
      per = (period_word == 16'd0) ? 16'd1 : period_word;
      nxt = {1'b0, tick_cnt} + 17'd1;
      if (nxt >= {1'b0, per}) begin
        tick_cnt = 16'd0;
        if (fmt_code <= FMT_S16_SWAP) begin
          r = '{KIND_SAMPLE, held_word, 1'b0};
          return 1'b1;
        end
        return 1'b0;
      end
      tick_cnt = nxt[15:0];
      return 1'b0;
    end
    // Line row from the two drive bits, source row from the mux.
    split = (f.bit_source != f.bit_sink);
    row = split ? LINE_SPLIT : (f.bit_source ? LINE_HIGH : LINE_LOW);
    src = f.mux_enable ? {1'b0, f.source_select} : SRC_MUTED;
    gain = mv_volts(SRC_GAIN_MV[src][row]);
    volts = mv_volts(SRC_OFFSET_MV[src][row]);
    if (src == SRC_DAC)
      volts += (longint'(f.dac_value) * gain) / 63;
    else if (src == SRC_TAPE)
      volts += (longint'(f.tape_level) * gain) / 255;
    scale = (32767 * ((vol_pct > 7'd100) ? 100 : vol_pct)) / 470;
    o = 16'((volts * scale) >> FRAC);
    case (fmt_code)
      FMT_U8:       held_word = {8'h00, o[15:8] + U8_BIAS};
      FMT_S8:       held_word = {8'h00, o[15:8]};
      FMT_S16:      held_word = o;
      FMT_S16_SWAP: held_word = {o[7:0], o[15:8]};
      default: ;
    endcase
    r.kind = KIND_UPDATE;
    r.sample = held_word;
    r.sense = (split && volts < mv_volts(SENSE_THRESH_MV)) ? 1'b0 : 1'b1;
    return 1'b1;
  endfunction

  function automatic dir_row_t reg_row(input logic [CFG_IW-1:0] idx,
                                       input logic [CFG_DW-1:0] val);
    dir_row_t r;
    r = '{default: '0};
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic dir_row_t upd_row(input bit mux, input logic [1:0] sel, input bit src,
                                       input bit snk, input logic [5:0] dac,
                                       input logic [7:0] tape);
    dir_row_t r;
    r = '{default: '0};
    r.op = OP_UPDATE;
    r.f.mux_enable = mux;
    r.f.source_select = sel;
    r.f.bit_source = src;
    r.f.bit_sink = snk;
    r.f.dac_value = dac;
    r.f.tape_level = tape;
    return r;
  endfunction

  function automatic dir_row_t tick_row();
    dir_row_t r;
    r = '{default: '0};
    r.op = OP_TICK;
    return r;
  endfunction

  function automatic dir_row_t with_want(input dir_row_t r, input mix_out_t w);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got 0x%0h, want 0x%0h", cycles, what, got, want);
  endtask

  // Sender pacing: in bursty mode, bursts of random length separated by random gaps.
  task automatic pace();
    int unsigned gap;
    if (bursty) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 12);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
  endtask

  // Offers one beat until it is taken, then records what it must produce.
  task automatic offer(input logic op, input asmix_update_t f, input bit typed,
                       input mix_out_t want);
    mix_out_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, f};
    s_axis_tuser <= op;
    do @(posedge clk); while (!s_axis_tready);
    if (mixer_step(op, f, predicted))
      due_beats.push_back(typed ? want : predicted);
    pace();
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (due_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    apply_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Output side: every accepted beat is checked against the oldest prediction.
  always @(posedge clk) begin : out_check
    mix_out_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_beats.size() == 0) begin
        report_mismatch("beat with nothing pending, sample", m_axis_tdata[15:0], 0);
      end else begin
        want = due_beats.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("kind", m_axis_tuser, want.kind);
        if (m_axis_tdata[15:0] !== want.sample)
          report_mismatch("sample", m_axis_tdata[15:0], want.sample);
        if (m_axis_tdata[16] !== want.sense)
          report_mismatch("sense_bit", m_axis_tdata[16], want.sense);
      end
    end
  end

  // Receiver stall patterns, with a long hold-off on request.
  initial begin : rx_pacer
    rx_style_t style;
    int unsigned run_len;
    int unsigned on_len;
    int unsigned off_len;
    int unsigned hold_left;
    int unsigned i;
    bit rdy;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      style = rx_style_t'($urandom_range(0, 3));
      run_len = $urandom_range(16, 160);
      on_len = $urandom_range(1, 6);
      off_len = $urandom_range(1, 8);
      for (i = 0; i < run_len; i++) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
          hold_left--;
          rdy = 1'b0;
        end else begin
          case (style)
            RX_OPEN:   rdy = 1'b1;
            RX_COIN:   rdy = ($urandom_range(0, 1) == 1);
            RX_CHOKED: rdy = ($urandom_range(0, 3) == 0);
            default:   rdy = (i % (on_len + off_len)) < on_len;
          endcase
        end
        m_axis_tready <= rdy;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t script[$];
    mix_out_t none;
    asmix_update_t f;
    logic op;
    logic [6:0] vol;
    logic [2:0] fmt;
    logic [15:0] per;
    int unsigned ph;
    int unsigned k;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = OP_TICK;
    none = '0;

    // Directed script, starting from the reset settings (volume 100, s16, period 325).
    script.push_back(with_want(upd_row(0, 2'd0, 1, 0, 6'd0, 8'd0),
                               '{KIND_UPDATE, 16'h0000, 1'b0}));
    script.push_back(upd_row(1, 2'd0, 0, 0, 6'd63, 8'd0));
    script.push_back(upd_row(1, 2'd0, 1, 0, 6'd0, 8'd255));
    script.push_back(upd_row(1, 2'd1, 1, 1, 6'd0, 8'd255));
    script.push_back(upd_row(1, 2'd1, 0, 1, 6'd63, 8'd0));
    script.push_back(upd_row(1, 2'd2, 1, 1, 6'd21, 8'd170));
    script.push_back(upd_row(1, 2'd3, 0, 0, 6'd42, 8'd85));
    script.push_back(upd_row(0, 2'd3, 1, 1, 6'd63, 8'd255));
    // A zero period acts as one: every tick emits.
    script.push_back(reg_row(CFG_PERIOD, 16'd0));
    script.push_back(tick_row());
    script.push_back(tick_row());
    // A format write reloads the held sample with that format's silence code.
    script.push_back(reg_row(CFG_FORMAT, FMT_U8));
    script.push_back(with_want(tick_row(), '{KIND_SAMPLE, 16'h0080, 1'b0}));
    script.push_back(upd_row(1, 2'd0, 1, 1, 6'd63, 8'd0));
    script.push_back(reg_row(CFG_FORMAT, FMT_S8));
    script.push_back(upd_row(1, 2'd1, 0, 0, 6'd0, 8'd128));
    script.push_back(reg_row(CFG_FORMAT, FMT_S16_SWAP));
    script.push_back(upd_row(1, 2'd0, 1, 1, 6'd63, 8'd0));
    // Volume above full scale saturates.
    script.push_back(reg_row(CFG_VOLUME, 16'd127));
    script.push_back(upd_row(1, 2'd0, 1, 1, 6'd63, 8'd0));
    script.push_back(reg_row(CFG_VOLUME, 16'd0));
    script.push_back(upd_row(0, 2'd0, 0, 0, 6'd0, 8'd0));
    // Formats without output: updates answer with the held sample, ticks emit nothing.
    script.push_back(reg_row(CFG_FORMAT, FMT_NONE_LO));
    script.push_back(upd_row(1, 2'd0, 0, 0, 6'd63, 8'd255));
    script.push_back(tick_row());
    script.push_back(reg_row(CFG_FORMAT, FMT_NONE_HI));
    script.push_back(reg_row(CFG_VOLUME, 16'd100));
    script.push_back(tick_row());
    script.push_back(upd_row(1, 2'd1, 1, 1, 6'd0, 8'd255));
    // The unused register index must change nothing.
    script.push_back(reg_row(CFG_SPARE, 16'hffff));
    script.push_back(reg_row(CFG_FORMAT, FMT_S16));
    script.push_back(reg_row(CFG_PERIOD, 16'd10));
    repeat (5) script.push_back(tick_row());
    // Period lowered below the running count: the next tick emits.
    script.push_back(reg_row(CFG_PERIOD, 16'd3));
    script.push_back(tick_row());
    script.push_back(upd_row(1, 2'd0, 0, 1, 6'd33, 8'd0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    vol_pct = 7'(VOLUME_RESET);
    fmt_code = FMT_S16;
    period_word = PERIOD_RESET;
    held_word = silence_of(FMT_S16);
    tick_cnt = 16'd0;

    foreach (script[i]) begin
      if (script[i].is_reg) begin
        settle();
        write_reg(script[i].reg_idx, script[i].reg_val);
      end else begin
        offer(script[i].op, script[i].f, script[i].typed, script[i].want);
      end
    end

    // Random phases, each under its own register settings.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin vol = 7'd127; fmt = FMT_S16_SWAP; per = 16'd0; end
        1: begin vol = 7'd0; fmt = FMT_U8; per = 16'd1; end
        2: begin vol = 7'd100; fmt = FMT_NONE_HI; per = 16'hffff; end
        3: begin vol = 7'd1; fmt = FMT_S8; per = 16'd2; end
        default: begin
          vol = 7'($urandom_range(0, 127));
          fmt = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(FMT_NONE_LO, FMT_NONE_HI))
                                            : 3'($urandom_range(FMT_U8, FMT_S16_SWAP));
          per = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(7, 40))
                                            : 16'($urandom_range(0, 6));
        end
      endcase
      settle();
      write_reg(CFG_VOLUME, {9'($urandom_range(0, 511)), vol});
      write_reg(CFG_FORMAT, {13'($urandom_range(0, 8191)), fmt});
      write_reg(CFG_PERIOD, per);
      bursty = ($urandom_range(0, 2) != 0);
      burst_left = 0;
      for (k = 0; k < PHASE_BEATS; k++) begin
        // Long receiver hold-off while beats keep coming.
        if (ph == 3 && k == 20)
          hold_req = 1'b1;
        op = ($urandom_range(0, 1) == 0) ? OP_TICK : OP_UPDATE;
        f = asmix_update_t'(19'($urandom_range(0, 19'h7ffff)));
        f.mux_enable = ($urandom_range(0, 3) != 0);
        if ($urandom_range(0, 7) == 0)
          f.dac_value = ($urandom_range(0, 1) == 1) ? 6'd63 : 6'd0;
        if ($urandom_range(0, 7) == 0)
          f.tape_level = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
        offer(op, f, 1'b0, none);
      end
    end

    settle();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/asmix_pkg.sv
rtl/core/asmix_datapath.sv
rtl/core/asmix_ctrl.sv
rtl/core/audio_source_mixer_sampler_core.sv
test/audio_source_mixer_sampler_core_test.sv
